// ===== rtl/core/sba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, register indexes, reset values and the helper function of the
// slice buffer layout allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 40;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TOPICS   = 4'd0,
    REG_LOAD_FACTOR  = 4'd1,
    REG_MODEL_THRESH = 4'd2,
    REG_ALIAS_THRESH = 4'd3,
    REG_DELTA_THRESH = 4'd4,
    REG_MODEL_LIMIT  = 4'd5,
    REG_ALIAS_LIMIT  = 4'd6,
    REG_DELTA_LIMIT  = 4'd7
  } sba_reg_idx_t;

  localparam logic [20:0] NUM_TOPICS_RST   = 21'd1024;
  localparam logic [4:0]  LOAD_FACTOR_RST  = 5'd2;
  localparam logic [20:0] MODEL_THRESH_RST = 21'd256;
  localparam logic [20:0] ALIAS_THRESH_RST = 21'd682;
  localparam logic [20:0] DELTA_THRESH_RST = 21'd128;
  localparam logic [39:0] LIMIT_RST        = 40'd1073741824;

  // Largest sparse capacity; larger demands saturate here.
  localparam logic [29:0] CAP_MAX = 30'd536870912;

  // Sizing configuration seen by the sizer.
  typedef struct packed {
    logic [20:0] topic_count;
    logic [4:0]  load_mult;
    logic [20:0] model_thresh;
    logic [20:0] alias_thresh;
    logic [20:0] delta_thresh;
  } sba_size_cfg_t;

  // Per-word buffer decisions, capacities and region sizes.
  typedef struct packed {
    logic        m_dense;
    logic [29:0] m_cap;
    logic [30:0] m_size;
    logic        a_dense;
    logic [23:0] a_cap;
    logic [25:0] a_size;
    logic        d_dense;
    logic [29:0] d_cap;
    logic [30:0] d_size;
  } sba_sizes_t;

  // Smallest power of two not below x; zero for zero, saturated at CAP_MAX.
  function automatic logic [29:0] pow2_ceil(input logic [29:0] x);
    logic [29:0] y;
    begin
      y = x - 30'd1;
      y = y | (y >> 1);
      y = y | (y >> 2);
      y = y | (y >> 4);
      y = y | (y >> 8);
      y = y | (y >> 16);
      if (x == 30'd0) begin
        pow2_ceil = 30'd0;
      end else if (x >= CAP_MAX) begin
        pow2_ceil = CAP_MAX;
      end else begin
        pow2_ceil = y + 30'd1;
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/slice_buffer_layout_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slice_buffer_layout_allocator_core
// Places each word record's model, alias and delta buffers at the running
// offsets of their regions and opens a new slice when a region would overflow.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, the input register and the result register;
//   an accepted item moves on to the result register once that one is free.
// Throughput: one item per cycle while out_ready holds; the running-offset add,
//   limit compare and offset update for one word are combinational.
// Reset (rst_n low, synchronous) clears the running offsets, the position and
//   slice counters and both valid flags, and restores the register defaults.
// ----------------------------------------------------------------------------
module slice_buffer_layout_allocator_core #(
  parameter int unsigned FREQ_WIDTH = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [23:0]                  in_word_id,
  input  wire logic [23:0]                  in_tf,
  input  wire logic [23:0]                  in_local_tf,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [23:0]                       out_word_position,
  output logic                              out_new_slice,
  output logic [15:0]                       out_slice_number,
  output logic                              out_model_dense,
  output logic [39:0]                       out_model_offset,
  output logic [29:0]                       out_model_capacity,
  output logic                              out_alias_dense,
  output logic [39:0]                       out_alias_offset,
  output logic [23:0]                       out_alias_capacity,
  output logic                              out_delta_dense,
  output logic [39:0]                       out_delta_offset,
  output logic [29:0]                       out_delta_capacity,

  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sba_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an index beyond the
  // register list is accepted and ignored.
  // --------------------------------------------------------------------------
  sba_size_cfg_t size_cfg_r;
  logic [39:0]   model_limit_r;
  logic [39:0]   alias_limit_r;
  logic [39:0]   delta_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r.topic_count  <= NUM_TOPICS_RST;
      size_cfg_r.load_mult    <= LOAD_FACTOR_RST;
      size_cfg_r.model_thresh <= MODEL_THRESH_RST;
      size_cfg_r.alias_thresh <= ALIAS_THRESH_RST;
      size_cfg_r.delta_thresh <= DELTA_THRESH_RST;
      model_limit_r           <= LIMIT_RST;
      alias_limit_r           <= LIMIT_RST;
      delta_limit_r           <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_TOPICS:   size_cfg_r.topic_count  <= cfg_data[20:0];
        REG_LOAD_FACTOR:  size_cfg_r.load_mult    <= cfg_data[4:0];
        REG_MODEL_THRESH: size_cfg_r.model_thresh <= cfg_data[20:0];
        REG_ALIAS_THRESH: size_cfg_r.alias_thresh <= cfg_data[20:0];
        REG_DELTA_THRESH: size_cfg_r.delta_thresh <= cfg_data[20:0];
        REG_MODEL_LIMIT:  model_limit_r           <= cfg_data[39:0];
        REG_ALIAS_LIMIT:  alias_limit_r           <= cfg_data[39:0];
        REG_DELTA_LIMIT:  delta_limit_r           <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register refills whenever its item moves on to the
  // result register, so a waiting result stops the next item from being
  // accepted only while the input register is full. The word id is carried
  // for reference only and is not stored.
  // --------------------------------------------------------------------------
  logic        in_valid_r;
  logic [23:0] tf_r;
  logic [23:0] ltf_r;
  logic        out_valid_r;
  logic        out_slot;
  logic        in_fire;
  logic        out_load;

  assign out_slot = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || out_slot;
  assign in_fire  = in_valid && in_ready;
  assign out_load = in_valid_r && out_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (out_slot) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tf_r  <= in_tf;
      ltf_r <= in_local_tf;
    end
  end

  // --------------------------------------------------------------------------
  // Per-word sizing from the registered frequencies.
  // --------------------------------------------------------------------------
  sba_sizes_t sizes;

  sba_sizer #(
    .FREQ_WIDTH (FREQ_WIDTH)
  ) u_sizer (
    .tf    (tf_r),
    .ltf   (ltf_r),
    .cfg   (size_cfg_r),
    .sizes (sizes)
  );

  // --------------------------------------------------------------------------
  // Placement. Each region's end is the running offset plus the word's size.
  // If any end passes its limit the word opens a new slice and is placed at
  // offset zero in every region, even when the current slice is empty.
  // --------------------------------------------------------------------------
  logic [41:0] m_run_r, a_run_r, d_run_r;
  logic [41:0] m_run_nxt, a_run_nxt, d_run_nxt;
  logic [23:0] pos_r;
  logic [15:0] slice_r;
  logic [15:0] slice_nxt;
  logic [42:0] m_end, a_end, d_end;
  logic        open_slice;
  logic [41:0] m_place, a_place, d_place;

  assign m_end = {1'b0, m_run_r} + {12'd0, sizes.m_size};
  assign a_end = {1'b0, a_run_r} + {17'd0, sizes.a_size};
  assign d_end = {1'b0, d_run_r} + {12'd0, sizes.d_size};

  assign open_slice = (m_end > {3'd0, model_limit_r}) ||
                      (a_end > {3'd0, alias_limit_r}) ||
                      (d_end > {3'd0, delta_limit_r});

  always_comb begin
    if (open_slice) begin
      m_place   = '0;
      a_place   = '0;
      d_place   = '0;
      m_run_nxt = {11'd0, sizes.m_size};
      a_run_nxt = {16'd0, sizes.a_size};
      d_run_nxt = {11'd0, sizes.d_size};
      slice_nxt = slice_r + 16'd1;
    end else begin
      m_place   = m_run_r;
      a_place   = a_run_r;
      d_place   = d_run_r;
      m_run_nxt = m_end[41:0];
      a_run_nxt = a_end[41:0];
      d_run_nxt = d_end[41:0];
      slice_nxt = slice_r;
    end
  end

  // State advances only when the item moves into the result register, so
  // items are placed strictly in acceptance order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_run_r <= '0;
      a_run_r <= '0;
      d_run_r <= '0;
      pos_r   <= '0;
      slice_r <= '0;
    end else if (out_load) begin
      m_run_r <= m_run_nxt;
      a_run_r <= a_run_nxt;
      d_run_r <= d_run_nxt;
      pos_r   <= pos_r + 24'd1;
      slice_r <= slice_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_position  <= pos_r;
      out_new_slice      <= open_slice;
      out_slice_number   <= slice_nxt;
      out_model_dense    <= sizes.m_dense;
      out_model_offset   <= m_place[39:0];
      out_model_capacity <= sizes.m_cap;
      out_alias_dense    <= sizes.a_dense;
      out_alias_offset   <= a_place[39:0];
      out_alias_capacity <= sizes.a_cap;
      out_delta_dense    <= sizes.d_dense;
      out_delta_offset   <= d_place[39:0];
      out_delta_capacity <= sizes.d_cap;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A word that opens a slice sits at the start of every region.
  a_new_slice_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_slice) |->
      (out_model_offset == 40'd0 && out_alias_offset == 40'd0 &&
       out_delta_offset == 40'd0))
    else $error("new slice result not placed at offset zero");

  // Sparse model and delta capacities are zero or a power of two.
  a_sparse_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_model_dense || $onehot0(out_model_capacity)) &&
       (out_delta_dense || $onehot0(out_delta_capacity))))
    else $error("sparse capacity is not a power of two");

  // Each placed word advances the position counter by exactly one.
  a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (pos_r == $past(pos_r) + 24'd1))
    else $error("position counter did not advance by one");

  // The slice number moves only when the word opens a slice.
  a_slice_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !open_slice) |=> $stable(slice_r))
    else $error("slice counter moved without a new slice");

  // Input is held off only while both registers are full and the output stalls.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input held off without a full, stalled pipeline");

endmodule
`default_nettype wire

// ===== rtl/core/sba_sizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sba_sizer
// Combinational sizing of one word: dense or sparse choice, capacity and
// occupied size for the model, alias and delta regions.
// ----------------------------------------------------------------------------
module sba_sizer #(
  parameter int unsigned FREQ_WIDTH = 24
) (
  input  wire logic [23:0]           tf,
  input  wire logic [23:0]           ltf,
  input  wire sba_pkg::sba_size_cfg_t cfg,
  output sba_pkg::sba_sizes_t        sizes
);
  import sba_pkg::*;

  localparam logic [31:0] FREQ_TOP = (FREQ_WIDTH >= 24) ? 32'h00FF_FFFF :
                                     32'((64'd1 << FREQ_WIDTH) - 64'd1);

  logic [23:0] tf_c;
  logic [23:0] ltf_c;
  logic [28:0] m_demand;
  logic [29:0] d_demand;
  logic [29:0] m_pow;
  logic [29:0] d_pow;

  // Frequencies saturate at the top of the frequency range.
  assign tf_c  = ({8'd0, tf} > FREQ_TOP) ? FREQ_TOP[23:0] : tf;
  assign ltf_c = ({8'd0, ltf} > FREQ_TOP) ? FREQ_TOP[23:0] : ltf;

  assign m_demand = {24'd0, cfg.load_mult} * {5'd0, tf_c};
  assign d_demand = {24'd0, cfg.load_mult, 1'b0} * {6'd0, ltf_c};
  assign m_pow    = pow2_ceil({1'b0, m_demand});
  assign d_pow    = pow2_ceil(d_demand);

  always_comb begin
    sizes = '0;
    if (tf_c >= {3'd0, cfg.model_thresh}) begin
      sizes.m_dense = 1'b1;
      sizes.m_cap   = {9'd0, cfg.topic_count};
      sizes.m_size  = {10'd0, cfg.topic_count};
    end else begin
      sizes.m_dense = 1'b0;
      sizes.m_cap   = m_pow;
      sizes.m_size  = {m_pow, 1'b0};
    end

    if (tf_c >= {3'd0, cfg.alias_thresh}) begin
      sizes.a_dense = 1'b1;
      sizes.a_cap   = {3'd0, cfg.topic_count};
      sizes.a_size  = {4'd0, cfg.topic_count, 1'b0};
    end else begin
      sizes.a_dense = 1'b0;
      sizes.a_cap   = tf_c;
      sizes.a_size  = {1'b0, tf_c, 1'b0} + {2'd0, tf_c};
    end

    if (ltf_c >= {3'd0, cfg.delta_thresh}) begin
      sizes.d_dense = 1'b1;
      sizes.d_cap   = {9'd0, cfg.topic_count};
      sizes.d_size  = {10'd0, cfg.topic_count};
    end else begin
      sizes.d_dense = 1'b0;
      sizes.d_cap   = d_pow;
      sizes.d_size  = {d_pow, 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== test/placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_checker
// Watches the register, word and placement channels of the slice buffer
// layout allocator. It keeps its own copy of the registers and running
// offsets, works out the placement of every accepted word and compares it
// field by field with the placement that the block returns.
// ----------------------------------------------------------------------------
module placement_checker (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [23:0]                    in_tf,
  input  logic [23:0]                    in_local_tf,

  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [23:0]                    out_word_position,
  input  logic                           out_new_slice,
  input  logic [15:0]                    out_slice_number,
  input  logic                           out_model_dense,
  input  logic [39:0]                    out_model_offset,
  input  logic [29:0]                    out_model_capacity,
  input  logic                           out_alias_dense,
  input  logic [39:0]                    out_alias_offset,
  input  logic [23:0]                    out_alias_capacity,
  input  logic                           out_delta_dense,
  input  logic [39:0]                    out_delta_offset,
  input  logic [29:0]                    out_delta_capacity,

  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data,

  output int                             fail_count,
  output int                             pending,
  output int                             slices_opened
);
  import sba_pkg::*;

  localparam logic [63:0] OFFSET_MASK = (64'd1 << 42) - 64'd1;

  typedef struct {
    logic [23:0] word_position;
    logic        new_slice;
    logic [15:0] slice_number;
    logic        model_dense;
    logic [39:0] model_off;
    logic [29:0] model_capacity;
    logic        alias_dense;
    logic [39:0] alias_off;
    logic [23:0] alias_cap;
    logic        delta_dense;
    logic [39:0] delta_off;
    logic [29:0] delta_cap;
  } placement_t;

  // Register copy.
  logic [20:0] topic_count;
  logic [4:0]  load_mult;
  logic [20:0] model_thresh;
  logic [20:0] alias_thresh;
  logic [20:0] delta_thresh;
  logic [39:0] model_limit;
  logic [39:0] alias_limit;
  logic [39:0] delta_limit;

  // Running layout state.
  logic [41:0] model_end;
  logic [41:0] alias_end;
  logic [41:0] delta_end;
  logic [23:0] position_count;
  logic [15:0] slice_count;

  // New placements enter at the front; the oldest leaves from the back.
  placement_t  placement_q[$];

  function automatic longint unsigned round_up_pow2(input longint unsigned demand);
    longint unsigned p;
    p = 1;
    if (demand == 0) return 0;
    if (demand >= longint'(CAP_MAX)) return longint'(CAP_MAX);
    while (p < demand) p = p << 1;
    return p;
  endfunction

  // Sizes the three buffers of one word, places them and advances the layout.
  function automatic placement_t place_word(input logic [23:0] tf, input logic [23:0] ltf);
    placement_t      r;
    longint unsigned t, l, lf, topics;
    longint unsigned m_cap, m_size, a_cap, a_size, d_cap, d_size;
    longint unsigned m_off, a_off, d_off;
    logic            opened;
    t      = tf;
    l      = ltf;
    lf     = load_mult;
    topics = topic_count;
    opened = 1'b0;

    r.model_dense = (t >= model_thresh);
    if (r.model_dense) begin
      m_cap  = topics;
      m_size = topics;
    end else begin
      m_cap  = round_up_pow2(lf * t);
      m_size = 2 * m_cap;
    end
    r.alias_dense = (t >= alias_thresh);
    if (r.alias_dense) begin
      a_cap  = topics;
      a_size = 2 * topics;
    end else begin
      a_cap  = t;
      a_size = 3 * t;
    end
    r.delta_dense = (l >= delta_thresh);
    if (r.delta_dense) begin
      d_cap  = topics;
      d_size = topics;
    end else begin
      d_cap  = round_up_pow2(2 * lf * l);
      d_size = 2 * d_cap;
    end

    m_off = model_end;
    a_off = alias_end;
    d_off = delta_end;
    if (m_off + m_size > model_limit || a_off + a_size > alias_limit ||
        d_off + d_size > delta_limit) begin
      // Overflow in any region restarts every region of a fresh slice.
      opened      = 1'b1;
      slice_count = slice_count + 16'd1;
      m_off       = 0;
      a_off       = 0;
      d_off       = 0;
    end
    model_end = 42'((m_off + m_size) & OFFSET_MASK);
    alias_end = 42'((a_off + a_size) & OFFSET_MASK);
    delta_end = 42'((d_off + d_size) & OFFSET_MASK);

    r.word_position  = position_count;
    r.new_slice      = opened;
    r.slice_number   = slice_count;
    r.model_off      = 40'(m_off);
    r.model_capacity = 30'(m_cap);
    r.alias_off      = 40'(a_off);
    r.alias_cap      = 24'(a_cap);
    r.delta_off      = 40'(d_off);
    r.delta_cap      = 30'(d_cap);
    position_count   = position_count + 24'd1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_placement(input placement_t e);
    check_field("out_word_position",  64'(e.word_position),  64'(out_word_position));
    check_field("out_new_slice",      64'(e.new_slice),      64'(out_new_slice));
    check_field("out_slice_number",   64'(e.slice_number),   64'(out_slice_number));
    check_field("out_model_dense",    64'(e.model_dense),    64'(out_model_dense));
    check_field("out_model_offset",   64'(e.model_off),      64'(out_model_offset));
    check_field("out_model_capacity", 64'(e.model_capacity), 64'(out_model_capacity));
    check_field("out_alias_dense",    64'(e.alias_dense),    64'(out_alias_dense));
    check_field("out_alias_offset",   64'(e.alias_off),      64'(out_alias_offset));
    check_field("out_alias_capacity", 64'(e.alias_cap),      64'(out_alias_capacity));
    check_field("out_delta_dense",    64'(e.delta_dense),    64'(out_delta_dense));
    check_field("out_delta_offset",   64'(e.delta_off),      64'(out_delta_offset));
    check_field("out_delta_capacity", 64'(e.delta_cap),      64'(out_delta_capacity));
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_NUM_TOPICS:   topic_count  = d[20:0];
      REG_LOAD_FACTOR:  load_mult    = d[4:0];
      REG_MODEL_THRESH: model_thresh = d[20:0];
      REG_ALIAS_THRESH: alias_thresh = d[20:0];
      REG_DELTA_THRESH: delta_thresh = d[20:0];
      REG_MODEL_LIMIT:  model_limit  = d;
      REG_ALIAS_LIMIT:  alias_limit  = d;
      REG_DELTA_LIMIT:  delta_limit  = d;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      topic_count    = NUM_TOPICS_RST;
      load_mult      = LOAD_FACTOR_RST;
      model_thresh   = MODEL_THRESH_RST;
      alias_thresh   = ALIAS_THRESH_RST;
      delta_thresh   = DELTA_THRESH_RST;
      model_limit    = LIMIT_RST;
      alias_limit    = LIMIT_RST;
      delta_limit    = LIMIT_RST;
      model_end      = '0;
      alias_end      = '0;
      delta_end      = '0;
      position_count = '0;
      slice_count    = '0;
      fail_count     = 0;
      slices_opened  = 0;
      placement_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) placement_q.push_front(place_word(in_tf, in_local_tf));
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          $error("placement returned with no word waiting for one");
          fail_count++;
        end else begin
          if (out_new_slice === 1'b1) slices_opened++;
          check_placement(placement_q.pop_back());
        end
      end
      pending <= placement_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives word records and register writes into the slice buffer layout
// allocator and gives the verdict. A short directed part covers the field
// extremes, threshold edges, zero demand, the largest sparse capacities, zero
// thresholds and words larger than a region limit; random phases with fresh register
// settings follow, with random gaps and stalls on both channels outside the calm phase.
// ----------------------------------------------------------------------------
module testbench;
  import sba_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned WORDS_PER_PHASE = 193;
  localparam int unsigned IDLE_PERCENT    = 7;
  // The calm phase runs with no gaps or stalls on either side.
  localparam int unsigned CALM_PHASE      = 3;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam logic [23:0] FREQ_MAX        = 24'hFFFFFF;
  localparam logic [39:0] ALL_ONES        = {CFG_DATA_W{1'b1}};

  logic                  clk;
  logic                  rst_n;

  logic                  in_valid;
  logic                  in_ready;
  logic [23:0]           in_word_id;
  logic [23:0]           in_tf;
  logic [23:0]           in_local_tf;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [23:0]           out_word_position;
  logic                  out_new_slice;
  logic [15:0]           out_slice_number;
  logic                  out_model_dense;
  logic [39:0]           out_model_offset;
  logic [29:0]           out_model_capacity;
  logic                  out_alias_dense;
  logic [39:0]           out_alias_offset;
  logic [23:0]           out_alias_capacity;
  logic                  out_delta_dense;
  logic [39:0]           out_delta_offset;
  logic [29:0]           out_delta_capacity;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fail_count;
  int                    pending;
  int                    slices_opened;
  int                    cycle_count = 0;
  int                    words_sent  = 0;
  int                    settings    = 1;
  logic                  no_idle     = 1'b0;

  slice_buffer_layout_allocator_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_word_id         (in_word_id),
    .in_tf              (in_tf),
    .in_local_tf        (in_local_tf),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word_position  (out_word_position),
    .out_new_slice      (out_new_slice),
    .out_slice_number   (out_slice_number),
    .out_model_dense    (out_model_dense),
    .out_model_offset   (out_model_offset),
    .out_model_capacity (out_model_capacity),
    .out_alias_dense    (out_alias_dense),
    .out_alias_offset   (out_alias_offset),
    .out_alias_capacity (out_alias_capacity),
    .out_delta_dense    (out_delta_dense),
    .out_delta_offset   (out_delta_offset),
    .out_delta_capacity (out_delta_capacity),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  placement_checker u_placement_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_tf              (in_tf),
    .in_local_tf        (in_local_tf),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word_position  (out_word_position),
    .out_new_slice      (out_new_slice),
    .out_slice_number   (out_slice_number),
    .out_model_dense    (out_model_dense),
    .out_model_offset   (out_model_offset),
    .out_model_capacity (out_model_capacity),
    .out_alias_dense    (out_alias_dense),
    .out_alias_offset   (out_alias_offset),
    .out_alias_capacity (out_alias_capacity),
    .out_delta_dense    (out_delta_dense),
    .out_delta_offset   (out_delta_offset),
    .out_delta_capacity (out_delta_capacity),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .slices_opened      (slices_opened)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The placement side stalls at random, except during the calm phase.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PERCENT);
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("slice_buffer_layout_allocator_core test failed");
      $finish;
    end
  end

  // One register write; returns at the edge that accepted it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Offers one word record, after an occasional random gap. Valid stays high
  // between back-to-back items; only the gap loop and drain_words lower it.
  task automatic push_word(input logic [23:0] id, input logic [23:0] tf, input logic [23:0] ltf);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_word_id  <= id;
    in_tf       <= tf;
    in_local_tf <= ltf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering words and waits until every placement has come back, so
  // the block holds no work when the registers change. Every word yields a
  // placement, so an empty checker means an empty pipeline.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Frequencies spread over small values, the threshold neighborhood, a
  // medium range and the whole 24-bit field.
  function automatic logic [23:0] random_freq();
    case ($urandom_range(3, 0))
      0:       return 24'($urandom_range(300, 0));
      1:       return 24'($urandom_range(2048, 0));
      2:       return 24'($urandom_range(65535, 0));
      default: return 24'($urandom_range(16777215, 0));
    endcase
  endfunction

  // A random setting for one register, leaning toward the extremes. Raw
  // 40-bit data also exercises the bits the block masks off.
  function automatic logic [CFG_DATA_W-1:0] random_setting(input sba_reg_idx_t r);
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(5, 0);
    case (r) inside
      REG_NUM_TOPICS: begin
        case (pick)
          0:       return 40'd1;
          1:       return raw[39:0];
          2:       return 40'($urandom_range(1048576, 1));
          default: return 40'($urandom_range(4096, 1));
        endcase
      end
      REG_LOAD_FACTOR: begin
        case (pick)
          0:       return 40'd1;
          1:       return 40'd16;
          2:       return raw[39:0];
          default: return 40'($urandom_range(16, 1));
        endcase
      end
      REG_MODEL_THRESH, REG_ALIAS_THRESH, REG_DELTA_THRESH: begin
        case (pick)
          0:       return 40'd0;
          1:       return raw[39:0];
          2:       return 40'($urandom_range(1048576, 0));
          default: return 40'($urandom_range(2048, 0));
        endcase
      end
      default: begin
        // Region limits: small ones force frequent new slices.
        case (pick)
          0:       return 40'd0;
          1:       return 40'($urandom_range(1 << 20, 0));
          2:       return 40'($urandom_range(1 << 26, 0));
          3:       return raw[39:0];
          4:       return ALL_ONES;
          default: return LIMIT_RST;
        endcase
      end
    endcase
  endfunction

  task automatic program_random_settings();
    write_reg(REG_NUM_TOPICS,   random_setting(REG_NUM_TOPICS));
    write_reg(REG_LOAD_FACTOR,  random_setting(REG_LOAD_FACTOR));
    write_reg(REG_MODEL_THRESH, random_setting(REG_MODEL_THRESH));
    write_reg(REG_ALIAS_THRESH, random_setting(REG_ALIAS_THRESH));
    write_reg(REG_DELTA_THRESH, random_setting(REG_DELTA_THRESH));
    write_reg(REG_MODEL_LIMIT,  random_setting(REG_MODEL_LIMIT));
    write_reg(REG_ALIAS_LIMIT,  random_setting(REG_ALIAS_LIMIT));
    write_reg(REG_DELTA_LIMIT,  random_setting(REG_DELTA_LIMIT));
    // Now and then a write to an index past the register list, which the
    // block must ignore.
    if ($urandom_range(3, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(15, 8)), CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word_id  <= '0;
    in_tf       <= '0;
    in_local_tf <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero demand, field extremes and every threshold edge.
    push_word(24'h000000, 24'd0,    24'd0);
    push_word(FREQ_MAX,   FREQ_MAX, FREQ_MAX);
    push_word(24'h000001, 24'd1,    24'd1);
    push_word(24'h000002, 24'd255,  24'd127);
    push_word(24'h000003, 24'd256,  24'd128);
    push_word(24'h000004, 24'd681,  24'd0);
    push_word(24'h000005, 24'd682,  24'd129);
    push_word(24'h000006, 24'd3,    24'd5);
    push_word(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    push_word(24'h555555, 24'hAAAAAA, 24'h555555);
    push_word(24'h800000, 24'd257,  24'd126);
    push_word(24'h7FFFFF, 24'd100,  24'd100);
    drain_words();

    // All registers at their top values: the largest load factor gives the
    // largest sparse capacities.
    settings++;
    write_reg(REG_NUM_TOPICS,   ALL_ONES);
    write_reg(REG_LOAD_FACTOR,  ALL_ONES);
    write_reg(REG_MODEL_THRESH, ALL_ONES);
    write_reg(REG_ALIAS_THRESH, ALL_ONES);
    write_reg(REG_DELTA_THRESH, ALL_ONES);
    write_reg(REG_MODEL_LIMIT,  ALL_ONES);
    write_reg(REG_ALIAS_LIMIT,  ALL_ONES);
    write_reg(REG_DELTA_LIMIT,  ALL_ONES);
    cfg_valid <= 1'b0;
    push_word(24'h123456, FREQ_MAX,    FREQ_MAX);
    push_word(24'h000010, 24'd0,       24'd0);
    push_word(24'h000011, 24'd1,       24'd1);
    push_word(24'h000012, 24'd2097150, 24'd2097150);
    push_word(24'h000013, 24'd2097151, 24'd2097151);
    push_word(24'h000014, 24'd8658944, 24'd1);
    drain_words();

    // Zero thresholds make every buffer dense; zero limits make every word
    // larger than its region, so each one opens a slice of its own.
    settings++;
    write_reg(REG_NUM_TOPICS,   40'd1);
    write_reg(REG_LOAD_FACTOR,  40'd0);
    write_reg(REG_MODEL_THRESH, 40'd0);
    write_reg(REG_ALIAS_THRESH, 40'd0);
    write_reg(REG_DELTA_THRESH, 40'd0);
    write_reg(REG_MODEL_LIMIT,  40'd0);
    write_reg(REG_ALIAS_LIMIT,  40'd0);
    write_reg(REG_DELTA_LIMIT,  40'd0);
    cfg_valid <= 1'b0;
    push_word(24'h000020, 24'd0,    24'd0);
    push_word(24'h000021, FREQ_MAX, 24'd0);
    push_word(24'h000022, 24'd0,    FREQ_MAX);
    push_word(24'h000023, 24'd7,    24'd9);
    push_word(24'h000024, 24'd1,    24'd1);
    drain_words();

    // Random phases, each under fresh register settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settings++;
      program_random_settings();
      no_idle <= (phase == CALM_PHASE);
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        push_word(24'($urandom), random_freq(), random_freq());
      drain_words();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Placed %0d words under %0d register settings; %0d new slices opened.",
             words_sent, settings, slices_opened);
    if (fail_count == 0 && pending == 0) begin
      $display("slice_buffer_layout_allocator_core test passed");
    end else begin
      $display("slice_buffer_layout_allocator_core test failed");
    end
    $finish;
  end

endmodule

// ===== slice_buffer_layout_allocator_core.f =====
rtl/core/sba_pkg.sv
rtl/core/sba_sizer.sv
rtl/core/slice_buffer_layout_allocator_core.sv
test/placement_checker.sv
test/testbench.sv
